>>> rtl/psb_pkg.sv
// Package for the pixel shade and blend core: register indexes, pixel format codes
// and the constants of the shading arithmetic.
// Depends on nothing; used by pixel_shade_blend_core.
`default_nettype none

package psb_pkg;

    localparam int unsigned PIX_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned INTENS_W   = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPACITY  = 3'd0,
        REG_DARKEN   = 3'd1,
        REG_BG_RED   = 3'd2,
        REG_BG_GREEN = 3'd3,
        REG_BG_BLUE  = 3'd4,
        REG_FORMAT   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        FMT_555  = 2'd0,
        FMT_565  = 2'd1,
        FMT_888  = 2'd2,
        FMT_8888 = 2'd3
    } fmt_t;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Floor reciprocals for the two constant divisions; each leaves the
    // quotient at most one low, fixed by a single remainder compare.
    localparam int unsigned SPAN_DIV   = 10000;
    localparam int unsigned SPAN_SHIFT = 30;
    localparam int unsigned SPAN_RECIP = (1 << SPAN_SHIFT) / SPAN_DIV;
    localparam int unsigned LO_DIV     = 100;
    localparam int unsigned LO_SHIFT   = 23;
    localparam int unsigned LO_RECIP   = (1 << LO_SHIFT) / LO_DIV;

    // Cycles that s_tready stays low after reset or a register write, so the
    // three-deep chain of derived coefficient registers holds the new values.
    localparam int unsigned SETTLE_CYCLES = 2;

endpackage

`default_nettype wire

>>> rtl/pixel_shade_blend_core.sv
// Pixel shade and blend core: darkens each packed pixel and blends it toward a
// solid background color. Uses psb_pkg for codes and constants.
//
// Channel   Ports                              Payload
// s_        s_tvalid s_tready s_tdata[31:0]    pixel_in
// m_        m_tvalid m_tready m_tdata[31:0]    pixel_out
// cfg_      cfg_we cfg_index[2:0] cfg_wdata    opacity darken bg_* pixel_format
//
// One item is accepted per cycle unless stalled; each goes from the input register
// to the output register. The per-channel coefficients come from a three-stage
// registered chain fed by the configuration registers, so a settle counter holds
// s_tready low after reset and after every register write. When m_tready is low
// the output register holds its item and the input register can take one more.
`default_nettype none

module pixel_shade_blend_core
    import psb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [31:0] pixel_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [PIX_W-1:0]           m_tdata,   // [31:0] pixel_out
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(SETTLE_CYCLES + 1);
    localparam int unsigned NCH   = 3;
    localparam int unsigned PROD_W = INTENS_W + PCT_W;

    logic [PCT_W-1:0]    opacity_reg, darken_reg;
    logic [INTENS_W-1:0] bg_reg [NCH];
    fmt_t                format_reg;
    logic [CNT_W-1:0]    settle_reg, settle_next;

    logic [PCT_W-1:0]    op_c, dk_c;
    logic [13:0]         ab;
    logic [29:0]         span_y_next, span_y_reg, span_y2_reg;
    logic [PROD_W-1:0]   lo_x_reg [NCH], lo_x2_reg [NCH];
    logic [46:0]         span_prod;
    logic [15:0]         span_q0_reg, span_reg;
    logic [29:0]         span_rem;
    logic [39:0]         lo_prod [NCH];
    logic [15:0]         lo_q0_reg [NCH], lo_reg [NCH];
    logic [PROD_W-1:0]   lo_rem [NCH];

    logic                in_valid_reg;
    logic [PIX_W-1:0]    in_pix_reg;
    logic                advance, s_acc;
    logic [7:0]          ch_c [NCH], ch_q [NCH];
    logic [3:0]          ch_k [NCH];
    logic [PIX_W-1:0]    pix_next;

    function automatic logic [7:0] shade_chan(input logic [7:0] c, input logic [3:0] k,
                                              input logic [15:0] span, input logic [15:0] lo);
        logic [23:0] bg_term, t;
        logic [24:0] sum;
        bg_term = ({8'd0, lo} << k) - {8'd0, lo};
        t       = 24'(c) * 24'(span) + bg_term;
        sum     = 25'(t) + 25'(t[23:16]) + 25'd1;
        return sum[23:16];
    endfunction

    // Configuration registers and the settle counter.
    always_comb begin
        settle_next = settle_reg;
        if (cfg_we) begin
            settle_next = CNT_W'(SETTLE_CYCLES);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opacity_reg <= '0;
            darken_reg  <= '0;
            bg_reg[0]   <= '0;
            bg_reg[1]   <= '0;
            bg_reg[2]   <= '0;
            format_reg  <= FMT_8888;
            settle_reg  <= CNT_W'(SETTLE_CYCLES);
        end else begin
            settle_reg <= settle_next;
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    REG_OPACITY:  opacity_reg <= cfg_wdata[PCT_W-1:0];
                    REG_DARKEN:   darken_reg  <= cfg_wdata[PCT_W-1:0];
                    REG_BG_RED:   bg_reg[0]   <= cfg_wdata[INTENS_W-1:0];
                    REG_BG_GREEN: bg_reg[1]   <= cfg_wdata[INTENS_W-1:0];
                    REG_BG_BLUE:  bg_reg[2]   <= cfg_wdata[INTENS_W-1:0];
                    REG_FORMAT:   format_reg  <= fmt_t'(cfg_wdata[1:0]);
                    default: ;
                endcase
            end
        end
    end

    // Derived coefficients: span = 65535*(100-dk)*(100-op)/10000, lo = bg*op/100.
    always_comb begin
        op_c = (opacity_reg > PCT_FULL) ? PCT_FULL : opacity_reg;
        dk_c = (darken_reg > PCT_FULL) ? PCT_FULL : darken_reg;
        ab   = 14'(PCT_FULL - op_c) * 14'(PCT_FULL - dk_c);
        span_y_next = {ab, 16'd0} - 30'(ab);
        span_prod   = 47'(span_y_reg) * 47'(SPAN_RECIP);
        span_rem    = span_y2_reg - 30'(span_q0_reg) * 30'(SPAN_DIV);
        for (int i = 0; i < NCH; i++) begin
            lo_prod[i] = 40'(lo_x_reg[i]) * 40'(LO_RECIP);
            lo_rem[i]  = lo_x2_reg[i] - PROD_W'(lo_q0_reg[i]) * PROD_W'(LO_DIV);
        end
    end

    always_ff @(posedge aclk) begin
        span_y_reg  <= span_y_next;
        span_y2_reg <= span_y_reg;
        span_q0_reg <= span_prod[SPAN_SHIFT+15:SPAN_SHIFT];
        span_reg    <= (span_rem >= 30'(SPAN_DIV)) ? span_q0_reg + 16'd1 : span_q0_reg;
        for (int i = 0; i < NCH; i++) begin
            lo_x_reg[i]  <= PROD_W'(bg_reg[i]) * PROD_W'(op_c);
            lo_x2_reg[i] <= lo_x_reg[i];
            lo_q0_reg[i] <= lo_prod[i][LO_SHIFT+15:LO_SHIFT];
            lo_reg[i]    <= (lo_rem[i] >= PROD_W'(LO_DIV)) ? lo_q0_reg[i] + 16'd1
                                                           : lo_q0_reg[i];
        end
    end

    // Datapath from the input register to the output register.
    always_comb begin
        ch_c[0] = in_pix_reg[23:16];
        ch_c[1] = in_pix_reg[15:8];
        ch_c[2] = in_pix_reg[7:0];
        ch_k[0] = 4'd8;
        ch_k[1] = 4'd8;
        ch_k[2] = 4'd8;
        case (format_reg)
            FMT_555: begin
                ch_c[0] = {3'd0, in_pix_reg[14:10]};
                ch_c[1] = {3'd0, in_pix_reg[9:5]};
                ch_c[2] = {3'd0, in_pix_reg[4:0]};
                ch_k[0] = 4'd5;
                ch_k[1] = 4'd5;
                ch_k[2] = 4'd5;
            end
            FMT_565: begin
                ch_c[0] = {3'd0, in_pix_reg[15:11]};
                ch_c[1] = {2'd0, in_pix_reg[10:5]};
                ch_c[2] = {3'd0, in_pix_reg[4:0]};
                ch_k[0] = 4'd5;
                ch_k[1] = 4'd6;
                ch_k[2] = 4'd5;
            end
            default: ;
        endcase
        for (int i = 0; i < NCH; i++) begin
            ch_q[i] = shade_chan(ch_c[i], ch_k[i], span_reg, lo_reg[i]);
        end
        case (format_reg)
            FMT_555:  pix_next = {17'd0, ch_q[0][4:0], ch_q[1][4:0], ch_q[2][4:0]};
            FMT_565:  pix_next = {16'd0, ch_q[0][4:0], ch_q[1][5:0], ch_q[2][4:0]};
            FMT_888:  pix_next = {8'd0, ch_q[0], ch_q[1], ch_q[2]};
            FMT_8888: pix_next = {in_pix_reg[31:24], ch_q[0], ch_q[1], ch_q[2]};
            default:  pix_next = '0;
        endcase
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = (settle_reg == '0) && (!in_valid_reg || advance);
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            if (s_acc) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_tvalid <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_pix_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            m_tdata <= pix_next;
        end
    end

    a_no_accept_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !(s_tvalid && s_tready))
        else $error("item accepted one cycle after a register write");

    a_no_accept_after_write2: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> ##1 !(s_tvalid && s_tready))
        else $error("item accepted two cycles after a register write");

    a_coeff_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> (17'(span_reg) + 17'(lo_reg[0]) <= 17'd65535)
                      && (17'(span_reg) + 17'(lo_reg[2]) <= 17'd65535))
        else $error("blend coefficients exceed full scale");

    a_out_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result shown without an item in the input register");

endmodule

`default_nettype wire

>>> verif/tb_pixel_shade_blend_core.sv
`timescale 1ns / 1ps
// Testbench for pixel_shade_blend_core: streams pixels through the core under many register
// settings and idle patterns, and checks each result in order against a built-in predictor.
// Depends on psb_pkg and pixel_shade_blend_core.

module tb_pixel_shade_blend_core;
    import psb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint unsigned INTENS_MAX = 65535;
    localparam int MAX_CYCLES  = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int SEGMENTS    = 11;
    localparam int SEG_ITEMS   = 50;

    class pixel_shade_checker;
        logic [PCT_W-1:0]    opacity;
        logic [PCT_W-1:0]    darken;
        logic [INTENS_W-1:0] bg_red;
        logic [INTENS_W-1:0] bg_green;
        logic [INTENS_W-1:0] bg_blue;
        fmt_t                fmt;
        logic [PIX_W-1:0]    expected_pixels[$];
        int                  errors;

        function new();
            opacity  = '0;
            darken   = '0;
            bg_red   = '0;
            bg_green = '0;
            bg_blue  = '0;
            fmt      = FMT_8888;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_OPACITY:  opacity  = val[PCT_W-1:0];
                REG_DARKEN:   darken   = val[PCT_W-1:0];
                REG_BG_RED:   bg_red   = val;
                REG_BG_GREEN: bg_green = val;
                REG_BG_BLUE:  bg_blue  = val;
                REG_FORMAT:   fmt      = fmt_t'(val[1:0]);
                default: ;
            endcase
        endfunction

        function logic [7:0] shade_channel(logic [7:0] c, logic [7:0] full,
                                           logic [INTENS_W-1:0] bg);
            longint unsigned op, dk, lo, hi, t;
            op = (opacity > PCT_FULL) ? PCT_FULL : opacity;
            dk = (darken > PCT_FULL) ? PCT_FULL : darken;
            lo = (longint'(bg) * op) / LO_DIV;
            hi = (INTENS_MAX * (PCT_FULL - dk) * (PCT_FULL - op)) / SPAN_DIV + lo;
            t  = longint'(c) * (hi - lo) + longint'(full) * lo;
            return 8'(t / INTENS_MAX);
        endfunction

        function logic [PIX_W-1:0] shade_pixel(logic [PIX_W-1:0] p);
            logic [7:0]       r, g, b;
            logic [PIX_W-1:0] res;
            case (fmt)
                FMT_555: begin
                    r   = shade_channel({3'b0, p[14:10]}, 8'd31, bg_red);
                    g   = shade_channel({3'b0, p[9:5]}, 8'd31, bg_green);
                    b   = shade_channel({3'b0, p[4:0]}, 8'd31, bg_blue);
                    res = {17'b0, r[4:0], g[4:0], b[4:0]};
                end
                FMT_565: begin
                    r   = shade_channel({3'b0, p[15:11]}, 8'd31, bg_red);
                    g   = shade_channel({2'b0, p[10:5]}, 8'd63, bg_green);
                    b   = shade_channel({3'b0, p[4:0]}, 8'd31, bg_blue);
                    res = {16'b0, r[4:0], g[5:0], b[4:0]};
                end
                default: begin
                    r   = shade_channel(p[23:16], 8'd255, bg_red);
                    g   = shade_channel(p[15:8], 8'd255, bg_green);
                    b   = shade_channel(p[7:0], 8'd255, bg_blue);
                    res = {8'b0, r, g, b};
                    if (fmt == FMT_8888) begin
                        res[31:24] = p[31:24];
                    end
                end
            endcase
            return res;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] p);
            expected_pixels.push_back(shade_pixel(p));
        endfunction

        function void check_pixel(logic [PIX_W-1:0] actual);
            logic [PIX_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("Unexpected output pixel %h at %0t.", actual, $realtime);
                end
            end else begin
                want = expected_pixels.pop_front();
                if (want !== actual) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("Pixel mismatch at %0t: expected %h, got %h.",
                                 $realtime, want, actual);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [PIX_W-1:0]      m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int cycle_count    = 0;

    pixel_shade_checker shade_sb = new();

    pixel_shade_blend_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                shade_sb.note_pixel(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                shade_sb.check_pixel(m_tdata);
            end
        end
    end

    initial begin : receiver
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < MAX_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pixel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (shade_sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        shade_sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] op, input logic [CFG_DATA_W-1:0] dk,
                                  input logic [CFG_DATA_W-1:0] red,
                                  input logic [CFG_DATA_W-1:0] green,
                                  input logic [CFG_DATA_W-1:0] blue,
                                  input logic [CFG_DATA_W-1:0] fmt_word);
        write_reg(REG_OPACITY, op);
        write_reg(REG_DARKEN, dk);
        write_reg(REG_BG_RED, red);
        write_reg(REG_BG_GREEN, green);
        write_reg(REG_BG_BLUE, blue);
        write_reg(REG_FORMAT, fmt_word);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_pct();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(3))
            0:       v[PCT_W-1:0] = '0;
            1:       v[PCT_W-1:0] = PCT_FULL;
            2:       v[PCT_W-1:0] = PCT_W'($urandom_range(127, 101));
            default: v[PCT_W-1:0] = PCT_W'($urandom_range(100, 0));
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_intensity();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int               seg;
        logic [PIX_W-1:0] px;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: 32bpp, no shading.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h1234_5678);
        drain();

        // Full opacity in 555; bit 15 and the upper half of the input are ignored.
        apply_settings(16'd100, 16'd0, 16'hFFFF, 16'h0000, 16'h8000, FMT_555);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_7FFF);
        send_pixel(32'hFFFF_8000);
        drain();

        // Full darkening in 565.
        apply_settings(16'd0, 16'd100, 16'h8000, 16'hFFFF, 16'h0001, FMT_565);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_0000);
        drain();

        // Percentages above 100 saturate; upper write bits are dropped.
        apply_settings(16'hFFFF, 16'hFF65, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFE);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFF00_0000);
        drain();

        // Mid settings in 32bpp, top byte passed through.
        apply_settings(16'd50, 16'd25, 16'h4321, 16'hA5A5, 16'h5A5A, FMT_8888);
        send_pixel(32'hAA55_AA55);
        send_pixel(32'h55AA_55AA);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        drain();

        // Writes to indexes past the register list change nothing.
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        cfg_we <= 1'b0;
        send_pixel(32'h8080_8080);
        send_pixel(32'h7F7F_7F7F);
        drain();

        apply_settings(16'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000, FMT_565);
        send_pixel(32'h0000_FFFF);
        send_pixel(32'h0000_1234);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            apply_settings(random_pct(), random_pct(), random_intensity(),
                           random_intensity(), random_intensity(), CFG_DATA_W'($urandom));
            case (seg % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            if (seg == 4) begin
                hold_requests++;
            end
            repeat (SEG_ITEMS) begin
                case ($urandom_range(7))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = $urandom;
                endcase
                send_pixel(px);
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        repeat (10) @(posedge aclk);
        if (shade_sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/psb_pkg.sv
rtl/pixel_shade_blend_core.sv
verif/tb_pixel_shade_blend_core.sv
